/* hdl/axis_force_particle_update_top_defines.svh */
// Assertion macros for the axis force affector.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef AXIS_FORCE_PARTICLE_UPDATE_TOP_DEFINES_SVH
`define AXIS_FORCE_PARTICLE_UPDATE_TOP_DEFINES_SVH

// same-cycle implication
`define AFPU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("afpu assertion failed");

// next-cycle implication
`define AFPU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("afpu assertion failed");

`endif

/* hdl/afpu_pkg.sv */
// Shared types, constants and rounding helpers for the axis force affector.
// No dependencies.
package afpu_pkg;

  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned DIV_STAGES = 48;

  localparam logic signed [48:0] MAG_MAX   = 49'sd19660800;
  localparam logic signed [48:0] NEG_LIMIT = 49'sd140737488355328;

  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_AXIS_X,
    REG_AXIS_Y,
    REG_AXIS_Z,
    REG_STRENGTH,
    REG_CUTOFF
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [31:0] strength;
    logic        [30:0] cutoff;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] d_x;
    logic signed [31:0] d_y;
    logic signed [31:0] d_z;
    logic signed [31:0] f_x;
    logic signed [31:0] f_y;
    logic signed [31:0] f_z;
    logic signed [34:0] proj;
    logic               near;
  } qentry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    logic signed [31:0] f_x;
    logic signed [31:0] f_y;
    logic signed [31:0] f_z;
    logic               near;
    logic               zero;
    logic               ovf;
    logic               neg;
  } divtag_t;

  // divide by 2^14, round half away from zero
  function automatic logic signed [65:0] rnd14(input logic signed [65:0] x);
    logic signed [65:0] t;
    t = x + (x[65] ? 66'sd8191 : 66'sd8192);
    return t >>> 14;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [65:0] x);
    logic [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* hdl/afpu_front.sv */
// Front end: accepts particles, forms offsets, runs the cutoff test and the
// axis projection, and pushes classified transactions into the queue. Uses afpu_pkg.
module afpu_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  afpu_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_pos_x,
  input  logic signed [31:0]   in_pos_y,
  input  logic signed [31:0]   in_pos_z,
  input  logic signed [31:0]   in_force_in_x,
  input  logic signed [31:0]   in_force_in_y,
  input  logic signed [31:0]   in_force_in_z,
  input  afpu_pkg::qstat_t     qstat,
  output logic                 push,
  output afpu_pkg::qentry_t    push_data
);
  import afpu_pkg::*;

  logic en;

  logic               v1_r, v2_r, v3_r;
  logic signed [32:0] dx1_r, dy1_r, dz1_r;
  logic signed [31:0] fx1_r, fy1_r, fz1_r;

  logic [32:0]        adx, ady, adz;
  logic [61:0]        sqx2_r, sqy2_r, sqz2_r;
  logic signed [47:0] dpx2_r, dpy2_r, dpz2_r;
  logic               in31_2_r;
  logic signed [31:0] dx2_r, dy2_r, dz2_r;
  logic signed [31:0] fx2_r, fy2_r, fz2_r;
  logic [61:0]        csq_r;

  logic [63:0]        dist2;
  logic signed [49:0] dot;
  logic signed [65:0] proj_full;
  qentry_t            e3_r;

  assign en       = !(v3_r && qstat.full);
  assign in_ready = en;
  assign push     = v3_r && !qstat.full;
  assign push_data = e3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    csq_r <= 62'(cfg.cutoff) * 62'(cfg.cutoff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r <= 33'(in_pos_x) - 33'(cfg.origin_x);
      dy1_r <= 33'(in_pos_y) - 33'(cfg.origin_y);
      dz1_r <= 33'(in_pos_z) - 33'(cfg.origin_z);
      fx1_r <= in_force_in_x;
      fy1_r <= in_force_in_y;
      fz1_r <= in_force_in_z;
    end
  end

  assign adx = dx1_r[32] ? 33'(-dx1_r) : 33'(dx1_r);
  assign ady = dy1_r[32] ? 33'(-dy1_r) : 33'(dy1_r);
  assign adz = dz1_r[32] ? 33'(-dz1_r) : 33'(dz1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      in31_2_r <= (adx[32:31] == 2'b00) && (ady[32:31] == 2'b00) &&
                  (adz[32:31] == 2'b00);
      sqx2_r   <= 62'(adx[30:0]) * 62'(adx[30:0]);
      sqy2_r   <= 62'(ady[30:0]) * 62'(ady[30:0]);
      sqz2_r   <= 62'(adz[30:0]) * 62'(adz[30:0]);
      dpx2_r   <= 48'(signed'(dx1_r[31:0])) * 48'(cfg.axis_x);
      dpy2_r   <= 48'(signed'(dy1_r[31:0])) * 48'(cfg.axis_y);
      dpz2_r   <= 48'(signed'(dz1_r[31:0])) * 48'(cfg.axis_z);
      dx2_r    <= signed'(dx1_r[31:0]);
      dy2_r    <= signed'(dy1_r[31:0]);
      dz2_r    <= signed'(dz1_r[31:0]);
      fx2_r    <= fx1_r;
      fy2_r    <= fy1_r;
      fz2_r    <= fz1_r;
    end
  end

  assign dist2     = 64'(sqx2_r) + 64'(sqy2_r) + 64'(sqz2_r);
  assign dot       = 50'(dpx2_r) + 50'(dpy2_r) + 50'(dpz2_r);
  assign proj_full = rnd14(66'(dot));

  always_ff @(posedge clk) begin
    if (en) begin
      e3_r.d_x  <= dx2_r;
      e3_r.d_y  <= dy2_r;
      e3_r.d_z  <= dz2_r;
      e3_r.f_x  <= fx2_r;
      e3_r.f_y  <= fy2_r;
      e3_r.f_z  <= fz2_r;
      e3_r.proj <= signed'(proj_full[34:0]);
      e3_r.near <= in31_2_r && !(dist2 > 64'(csq_r));
    end
  end

endmodule

/* hdl/afpu_queue.sv */
// Short queue between the front and back ends.
// Uses afpu_pkg for the entry type and depth.
module afpu_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  afpu_pkg::qentry_t    push_data,
  input  logic                 pop,
  output afpu_pkg::qentry_t    pop_data,
  output afpu_pkg::qstat_t     qstat
);
  import afpu_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  qentry_t       ent_r [QDEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign qstat.full  = (cnt_r == (PW+1)'(QDEPTH));
  assign qstat.empty = (cnt_r == '0);
  assign pop_data    = ent_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

/* hdl/afpu_div.sv */
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// Uses afpu_pkg for the tag type and stage count.
module afpu_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [63:0]        rem0,
  input  logic [63:0]        den,
  input  logic [15:0]        nlo,
  input  afpu_pkg::divtag_t  tag_in,
  output logic               out_valid,
  output logic [47:0]        quo,
  output afpu_pkg::divtag_t  tag_out
);
  import afpu_pkg::*;

  logic          vld_r [DIV_STAGES];
  logic [63:0]   rem_r [DIV_STAGES];
  logic [63:0]   den_r [DIV_STAGES];
  logic [15:0]   nlo_r [DIV_STAGES];
  logic [47:0]   q_r   [DIV_STAGES];
  divtag_t       tag_r [DIV_STAGES];

  logic          s_vld [DIV_STAGES];
  logic [63:0]   s_rem [DIV_STAGES];
  logic [63:0]   s_den [DIV_STAGES];
  logic [15:0]   s_nlo [DIV_STAGES];
  logic [47:0]   s_q   [DIV_STAGES];
  divtag_t       s_tag [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic        nb;
    logic [64:0] sh;
    logic [64:0] df;
    logic        ge;

    if (k == 0) begin : g_first
      assign s_vld[k] = in_valid;
      assign s_rem[k] = rem0;
      assign s_den[k] = den;
      assign s_nlo[k] = nlo;
      assign s_q[k]   = '0;
      assign s_tag[k] = tag_in;
    end else begin : g_next
      assign s_vld[k] = vld_r[k-1];
      assign s_rem[k] = rem_r[k-1];
      assign s_den[k] = den_r[k-1];
      assign s_nlo[k] = nlo_r[k-1];
      assign s_q[k]   = q_r[k-1];
      assign s_tag[k] = tag_r[k-1];
    end

    if (k < 16) begin : g_nbit
      assign nb = s_nlo[k][15-k];
    end else begin : g_zbit
      assign nb = 1'b0;
    end

    assign sh = {s_rem[k], nb};
    assign df = sh - {1'b0, s_den[k]};
    assign ge = (sh >= {1'b0, s_den[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= s_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? df[63:0] : sh[63:0];
        den_r[k] <= s_den[k];
        nlo_r[k] <= s_nlo[k];
        q_r[k]   <= {s_q[k][46:0], ge};
        tag_r[k] <= s_tag[k];
      end
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign quo       = q_r[DIV_STAGES-1];
  assign tag_out   = tag_r[DIV_STAGES-1];

endmodule

/* hdl/afpu_back.sv */
// Back end: perpendicular length, magnitude division, force update and the
// output register. Uses afpu_pkg and instantiates afpu_div.
module afpu_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  afpu_pkg::cfg_t       cfg,
  input  afpu_pkg::qstat_t     qstat,
  output logic                 pop,
  input  afpu_pkg::qentry_t    pop_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_force_out_x,
  output logic signed [31:0]   out_force_out_y,
  output logic signed [31:0]   out_force_out_z,
  output logic                 out_affected
);
  import afpu_pkg::*;

  logic adv;

  logic               v0_r, v1_r, v2_r, v3_r, v4_r, vm0_r, vm1_r, out_valid_r;
  qentry_t            e0_r, e1_r, e2_r, e3_r, e4_r;
  logic signed [50:0] prx1_r, pry1_r, prz1_r;

  logic signed [65:0] vx, vy, vz;
  logic [65:0]        avx, avy, avz;
  logic [31:0]        ax2_r, ay2_r, az2_r;
  logic               big2_r, big3_r;
  logic [63:0]        sqx3_r, sqy3_r, sqz3_r;
  logic [65:0]        lsum;
  logic [63:0]        len4_r;

  logic [32:0]        sabs;
  divtag_t            dtag_in, dtag_out, tm0_r, tm1_r;
  logic               dvld;
  logic [47:0]        quo;
  logic signed [48:0] mag_nxt, mag_r;
  logic signed [64:0] pdx_r, pdy_r, pdz_r;

  logic [31:0]        fox_nxt, foy_nxt, foz_nxt;
  logic [31:0]        fox_r, foy_r, foz_r;
  logic               aff_r;

  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      vm0_r       <= 1'b0;
      vm1_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= !qstat.empty;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      vm0_r       <= dvld;
      vm1_r       <= vm0_r;
      out_valid_r <= vm1_r;
    end
  end

  assign vx  = rnd14(66'(prx1_r)) - 66'(e1_r.d_x);
  assign vy  = rnd14(66'(pry1_r)) - 66'(e1_r.d_y);
  assign vz  = rnd14(66'(prz1_r)) - 66'(e1_r.d_z);
  assign avx = vx[65] ? 66'(-vx) : 66'(vx);
  assign avy = vy[65] ? 66'(-vy) : 66'(vy);
  assign avz = vz[65] ? 66'(-vz) : 66'(vz);

  assign lsum = 66'(sqx3_r) + 66'(sqy3_r) + 66'(sqz3_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      e0_r   <= pop_data;
      prx1_r <= 51'(cfg.axis_x) * 51'(e0_r.proj);
      pry1_r <= 51'(cfg.axis_y) * 51'(e0_r.proj);
      prz1_r <= 51'(cfg.axis_z) * 51'(e0_r.proj);
      e1_r   <= e0_r;
      ax2_r  <= avx[31:0];
      ay2_r  <= avy[31:0];
      az2_r  <= avz[31:0];
      big2_r <= (|avx[65:32]) || (|avy[65:32]) || (|avz[65:32]);
      e2_r   <= e1_r;
      sqx3_r <= 64'(ax2_r) * 64'(ax2_r);
      sqy3_r <= 64'(ay2_r) * 64'(ay2_r);
      sqz3_r <= 64'(az2_r) * 64'(az2_r);
      big3_r <= big2_r;
      e3_r   <= e2_r;
      len4_r <= (big3_r || (|lsum[65:64])) ? '1 : lsum[63:0];
      e4_r   <= e3_r;
    end
  end

  assign sabs = cfg.strength[31] ? 33'(-cfg.strength) : 33'(cfg.strength);

  always_comb begin
    dtag_in.f_x  = e4_r.f_x;
    dtag_in.f_y  = e4_r.f_y;
    dtag_in.f_z  = e4_r.f_z;
    dtag_in.near = e4_r.near;
    dtag_in.zero = (len4_r == '0);
    dtag_in.ovf  = (64'(sabs[31:16]) >= len4_r);
    dtag_in.neg  = cfg.strength[31];
  end

  afpu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v4_r),
    .rem0      (64'(sabs[31:16])),
    .den       (len4_r),
    .nlo       (sabs[15:0]),
    .tag_in    (dtag_in),
    .out_valid (dvld),
    .quo       (quo),
    .tag_out   (dtag_out)
  );

  always_comb begin
    if (dtag_out.zero) begin
      mag_nxt = MAG_MAX;
    end else if (!dtag_out.neg) begin
      mag_nxt = (dtag_out.ovf || (49'(quo) > MAG_MAX)) ? MAG_MAX : 49'(quo);
    end else begin
      mag_nxt = (dtag_out.ovf || (49'(quo) > NEG_LIMIT)) ? -NEG_LIMIT : -49'(quo);
    end
  end

  always_comb begin
    if (tm1_r.near) begin
      fox_nxt = sat32(66'(tm1_r.f_x) - rnd14(66'(pdx_r)));
      foy_nxt = sat32(66'(tm1_r.f_y) - rnd14(66'(pdy_r)));
      foz_nxt = sat32(66'(tm1_r.f_z) - rnd14(66'(pdz_r)));
    end else begin
      fox_nxt = tm1_r.f_x;
      foy_nxt = tm1_r.f_y;
      foz_nxt = tm1_r.f_z;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mag_r <= mag_nxt;
      tm0_r <= dtag_out;
      pdx_r <= 65'(mag_r) * 65'(cfg.axis_x);
      pdy_r <= 65'(mag_r) * 65'(cfg.axis_y);
      pdz_r <= 65'(mag_r) * 65'(cfg.axis_z);
      tm1_r <= tm0_r;
      fox_r <= fox_nxt;
      foy_r <= foy_nxt;
      foz_r <= foz_nxt;
      aff_r <= tm1_r.near;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_force_out_x = fox_r;
  assign out_force_out_y = foy_r;
  assign out_force_out_z = foz_r;
  assign out_affected    = aff_r;

endmodule

/* hdl/axis_force_particle_update_top.sv */
// Top level of the axis force affector: configuration registers, APB port,
// front end, queue and back end. Uses afpu_pkg and the assertion macro header.
//
//  channel  | handshake         | payload
//  ---------+-------------------+-----------------------------------------
//  in       | in_valid/in_ready | in_pos_x/y/z, in_force_in_x/y/z
//  out      | out_valid/ready   | out_force_out_x/y/z, out_affected
//  cfg      | psel/penable      | paddr, pwrite, pwdata, prdata, pready
//
// One transaction per cycle sustained while the output is not held; most of the
// pipeline from input to result lies in the 48-stage divider.
// Reset is synchronous: control clears and the registers take their defaults.
// A held output stalls the back end; the four-entry queue lets the front end
// keep accepting until it fills.
`include "axis_force_particle_update_top_defines.svh"

module axis_force_particle_update_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_force_in_x,
  input  logic signed [31:0] in_force_in_y,
  input  logic signed [31:0] in_force_in_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_force_out_x,
  output logic signed [31:0] out_force_out_y,
  output logic signed [31:0] out_force_out_z,
  output logic               out_affected,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import afpu_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t ridx;
  qstat_t   qstat;
  logic     push, pop;
  qentry_t  push_data, pop_data;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign ridx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
      cfg_r.origin_z <= '0;
      cfg_r.axis_x   <= '0;
      cfg_r.axis_y   <= '0;
      cfg_r.axis_z   <= -16'sd16384;
      cfg_r.strength <= 32'sd65536;
      cfg_r.cutoff   <= 31'd65536;
    end else if (wr_en) begin
      case (ridx)
        REG_ORIGIN_X: cfg_r.origin_x <= signed'(pwdata);
        REG_ORIGIN_Y: cfg_r.origin_y <= signed'(pwdata);
        REG_ORIGIN_Z: cfg_r.origin_z <= signed'(pwdata);
        REG_AXIS_X:   cfg_r.axis_x   <= signed'(pwdata[15:0]);
        REG_AXIS_Y:   cfg_r.axis_y   <= signed'(pwdata[15:0]);
        REG_AXIS_Z:   cfg_r.axis_z   <= signed'(pwdata[15:0]);
        REG_STRENGTH: cfg_r.strength <= signed'(pwdata);
        REG_CUTOFF:   cfg_r.cutoff   <= pwdata[30:0];
        default:      cfg_r          <= cfg_r;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_ORIGIN_X: prdata = cfg_r.origin_x;
      REG_ORIGIN_Y: prdata = cfg_r.origin_y;
      REG_ORIGIN_Z: prdata = cfg_r.origin_z;
      REG_AXIS_X:   prdata = 32'(cfg_r.axis_x);
      REG_AXIS_Y:   prdata = 32'(cfg_r.axis_y);
      REG_AXIS_Z:   prdata = 32'(cfg_r.axis_z);
      REG_STRENGTH: prdata = cfg_r.strength;
      REG_CUTOFF:   prdata = {1'b0, cfg_r.cutoff};
      default:      prdata = '0;
    endcase
  end

  afpu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_force_in_x (in_force_in_x),
    .in_force_in_y (in_force_in_y),
    .in_force_in_z (in_force_in_z),
    .qstat         (qstat),
    .push          (push),
    .push_data     (push_data)
  );

  afpu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  afpu_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .qstat           (qstat),
    .pop             (pop),
    .pop_data        (pop_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_force_out_x (out_force_out_x),
    .out_force_out_y (out_force_out_y),
    .out_force_out_z (out_force_out_z),
    .out_affected    (out_affected)
  );

  `AFPU_ASSERT_IMP(a_stall_only_full, !in_ready, qstat.full)
  `AFPU_ASSERT_IMP(a_pop_nonempty, pop, !qstat.empty)
  `AFPU_ASSERT_IMP(a_full_not_empty, qstat.full, !qstat.empty)
  `AFPU_ASSERT_NXT(a_push_fills, push && !pop, !qstat.empty)

endmodule

/* tb/sv/axis_force_particle_update_top_test.sv */
// Self-checking test of the axis force affector: random and directed particles,
// APB register phases, random idling on both channels. Depends on afpu_pkg.
module axis_force_particle_update_top_test;
  import afpu_pkg::*;

  localparam int N_RANDOM    = 1600;
  localparam int WDOG_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 120;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic signed [31:0] px, py, pz, fx, fy, fz;
  } particle_t;

  typedef struct packed {
    logic signed [31:0] fx, fy, fz;
    logic               hit;
  } force_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [31:0] in_force_in_x = '0, in_force_in_y = '0, in_force_in_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_force_out_x, out_force_out_y, out_force_out_z;
  logic out_affected;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  axis_force_particle_update_top u_top (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // affector settings as seen by the predictor
  logic signed [31:0] org_x, org_y, org_z, strength_q;
  logic signed [15:0] ax_x, ax_y, ax_z;
  logic [30:0] cutoff_q;

  particle_t  pending_particles[$];
  force_res_t expected_forces[$];
  int errors = 0;
  int mismatches = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int hold_cnt = 0;
  int src_gap = 0, sink_gap = 0, idle_cycles = 0;

  function automatic logic signed [65:0] round14(input logic signed [65:0] x);
    logic [65:0] a;
    a = x[65] ? 66'(-x) : 66'(x);
    a = (a + 66'd8192) >> 14;
    return x[65] ? -$signed(a) : $signed(a);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [65:0] x);
    if (x > 66'sd2147483647) return 32'sh7fffffff;
    if (x < -66'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic force_res_t apply_affector(input particle_t p);
    logic signed [65:0] d[3], f[3], ax[3], v, mag;
    logic signed [65:0] proj;
    logic [65:0] a, dist2, len2, q, cut2;
    logic [95:0] num;
    logic is_near;
    force_res_t r;
    ax[0] = ax_x; ax[1] = ax_y; ax[2] = ax_z;
    d[0] = 66'(p.px) - 66'(org_x);
    d[1] = 66'(p.py) - 66'(org_y);
    d[2] = 66'(p.pz) - 66'(org_z);
    f[0] = p.fx; f[1] = p.fy; f[2] = p.fz;
    is_near = 1'b1;
    dist2 = '0;
    for (int i = 0; i < 3; i++) begin
      a = d[i][65] ? 66'(-d[i]) : 66'(d[i]);
      if (a >= 66'd2147483648) is_near = 1'b0;
      dist2 += a * a;
    end
    cut2 = 66'(cutoff_q) * 66'(cutoff_q);
    if (is_near && dist2 > cut2) is_near = 1'b0;
    if (is_near) begin
      proj = round14(d[0] * ax[0] + d[1] * ax[1] + d[2] * ax[2]);
      len2 = '0;
      for (int i = 0; i < 3; i++) begin
        v = round14(ax[i] * proj) - d[i];
        a = v[65] ? 66'(-v) : 66'(v);
        if (a >= 66'h1_0000_0000) len2 = 66'hFFFF_FFFF_FFFF_FFFF;
        else begin
          len2 += a * a;
          if (len2 > 66'hFFFF_FFFF_FFFF_FFFF) len2 = 66'hFFFF_FFFF_FFFF_FFFF;
        end
      end
      if (len2 == 0) mag = 66'(MAG_MAX);
      else begin
        num = strength_q[31] ? 96'(-66'(strength_q)) : 96'(66'(strength_q));
        num = num << 32;
        q = 66'(num / 96'(len2));
        if (!strength_q[31]) mag = (q > 66'(MAG_MAX)) ? 66'(MAG_MAX) : $signed(q);
        else mag = -$signed((q > 66'(NEG_LIMIT)) ? 66'(NEG_LIMIT) : q);
      end
      for (int i = 0; i < 3; i++) f[i] = clip32(f[i] - round14(mag * ax[i]));
    end
    r.fx = f[0][31:0]; r.fy = f[1][31:0]; r.fz = f[2][31:0]; r.hit = is_near;
    return r;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 5'(idx) << 2; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_ORIGIN_X: org_x = val;
      REG_ORIGIN_Y: org_y = val;
      REG_ORIGIN_Z: org_z = val;
      REG_AXIS_X:   ax_x = val[15:0];
      REG_AXIS_Y:   ax_y = val[15:0];
      REG_AXIS_Z:   ax_z = val[15:0];
      REG_STRENGTH: strength_q = val;
      default:      cutoff_q = val[30:0];
    endcase
  endtask

  task automatic drain();
    while (pending_particles.size() != 0 || expected_forces.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_pick();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 8) << 16;
      3: return 32'(-int'($urandom_range(0, 8) << 16));
      4: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_setting(input bit extreme);
    int k;
    logic [15:0] u[3];
    k = $urandom_range(0, 3);
    u[0] = 0; u[1] = 0; u[2] = 0;
    if (k < 3) u[k] = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
    else begin
      u[0] = 16'sd9459; u[1] = -16'sd9459; u[2] = 16'sd9459;
    end
    if (extreme && $urandom_range(0, 1)) begin
      u[0] = 16'h8000; u[1] = 16'h7fff; u[2] = 16'h8000;
    end
    write_reg(REG_AXIS_X, {{16{u[0][15]}}, u[0]});
    write_reg(REG_AXIS_Y, {{16{u[1][15]}}, u[1]});
    write_reg(REG_AXIS_Z, {{16{u[2][15]}}, u[2]});
    write_reg(REG_ORIGIN_X, extreme ? rand_pick() : $urandom_range(0, 32'h3ffff) - 32'h1ffff);
    write_reg(REG_ORIGIN_Y, extreme ? rand_pick() : $urandom_range(0, 32'h3ffff) - 32'h1ffff);
    write_reg(REG_ORIGIN_Z, extreme ? rand_pick() : $urandom_range(0, 32'h3ffff) - 32'h1ffff);
    write_reg(REG_STRENGTH, extreme ? rand_pick() : $urandom_range(0, 32'h7ffff) - 32'h3ffff);
    write_reg(REG_CUTOFF, extreme ? ($urandom_range(0, 1) ? 32'h7fff_ffff : 32'h0)
                                  : $urandom_range(0, 32'h5ffff));
  endtask

  function automatic particle_t near_particle();
    particle_t p;
    p.px = org_x + ($urandom_range(0, 32'h2ffff) - 32'h17fff);
    p.py = org_y + ($urandom_range(0, 32'h2ffff) - 32'h17fff);
    p.pz = org_z + ($urandom_range(0, 32'h2ffff) - 32'h17fff);
    if ($urandom_range(0, 7) == 0) p.px = org_x;
    if ($urandom_range(0, 9) == 0) begin p.px = org_x; p.py = org_y; p.pz = org_z; end
    p.fx = rand_pick(); p.fy = rand_pick(); p.fz = rand_pick();
    return p;
  endfunction

  function automatic particle_t noise_particle();
    particle_t p;
    p.px = rand_pick(); p.py = rand_pick(); p.pz = rand_pick();
    p.fx = $urandom(); p.fy = $urandom(); p.fz = $urandom();
    return p;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_particles.size() != 0) begin
        if (idle_on && in_valid && $urandom_range(0, 9) == 0) begin
          src_gap <= $urandom_range(0, 14);
          in_valid <= 1'b0;
        end else begin
          particle_t p;
          p = pending_particles.pop_front();
          in_valid <= 1'b1;
          in_pos_x <= p.px; in_pos_y <= p.py; in_pos_z <= p.pz;
          in_force_in_x <= p.fx; in_force_in_y <= p.fy; in_force_in_z <= p.fz;
          expected_forces.push_back(apply_affector(p));
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // sink stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_gap <= 0;
    end else if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      sink_gap <= $urandom_range(0, 14);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("axis_force_particle_update_top_test: FAIL");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (expected_forces.size() == 0) begin
          errors++;
          $display("unexpected transaction: %h %h %h %b", out_force_out_x,
                   out_force_out_y, out_force_out_z, out_affected);
        end else begin
          force_res_t e;
          e = expected_forces.pop_front();
          if (e.fx !== out_force_out_x || e.fy !== out_force_out_y ||
              e.fz !== out_force_out_z || e.hit !== out_affected) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h %b got %h %h %h %b", e.fx, e.fy, e.fz,
                       e.hit, out_force_out_x, out_force_out_y, out_force_out_z,
                       out_affected);
          end
        end
      end
    end
  end

  initial begin
    particle_t p;
    org_x = 0; org_y = 0; org_z = 0;
    ax_x = 0; ax_y = 0; ax_z = -16384;
    strength_q = 65536; cutoff_q = 31'd65536;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: on axis, within cutoff, outside, boundary
    pending_particles.push_back('{0, 0, 0, 0, 0, 0});
    pending_particles.push_back('{32'sh8000, 0, 32'sh4000, 32'sh7fffffff, 0, 32'sh80000000});
    pending_particles.push_back('{32'sh10000, 0, 0, 1, 2, 3});
    pending_particles.push_back('{32'sh10001, 0, 0, 1, 2, 3});
    pending_particles.push_back('{32'sh80000000, 32'sh7fffffff, 0, 5, 6, 7});
    pending_particles.push_back('{32'sh100, 32'sh100, 0, 32'sh7fffffff, 32'sh7fffffff,
                                  32'sh7fffffff});
    pending_particles.push_back('{32'sh20, 0, 0, 0, 0, 32'sh80000000});
    drain();

    // extremes: full cutoff, negative strength, odd axis
    write_reg(REG_CUTOFF, 32'h7fff_ffff);
    write_reg(REG_STRENGTH, 32'h8000_0000);
    write_reg(REG_AXIS_X, 32'hffff_8000);
    write_reg(REG_AXIS_Y, 32'h0000_7fff);
    write_reg(REG_ORIGIN_X, 32'h7fff_ffff);
    write_reg(REG_ORIGIN_Y, 32'h8000_0000);
    write_reg(REG_ORIGIN_Z, 32'h0);
    pending_particles.push_back('{32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, 0});
    pending_particles.push_back('{32'h0, 32'h0, 32'h4000_0000, 1, 1, 1});
    pending_particles.push_back('{32'h4000_0000, 32'hc000_0000, 32'hc000_0000,
                                  32'h8000_0000, 32'h7fff_ffff, 0});
    pending_particles.push_back('{32'h7fff_0000, 32'h8000_1000, 32'h100, 9, 9, 9});
    drain();
    write_reg(REG_STRENGTH, 32'h7fff_ffff);
    write_reg(REG_AXIS_X, 32'h0000_4000);
    write_reg(REG_AXIS_Y, 32'h0);
    write_reg(REG_AXIS_Z, 32'h0);
    pending_particles.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h7fff, 0, 0, 0});
    pending_particles.push_back('{32'h7fff_ffff, 32'h7fff_ffff, 32'h0, 0, 0, 0});
    pending_particles.push_back('{32'h0, 32'h8000_0001, 32'h1, 32'h8000_0000, 0, 0});
    drain();
    write_reg(REG_CUTOFF, 32'h0);
    pending_particles.push_back('{32'h7fff_ffff, 32'h8000_0000, 32'h0, 0, 0, 0});
    pending_particles.push_back('{32'h7fff_ffff, 32'h8000_0001, 32'h0, 0, 0, 0});
    drain();

    // random phases
    for (int ph = 0; ph < 17; ph++) begin
      random_setting(ph % 4 == 3);
      if (ph == 15) idle_on = 1'b0;
      if (ph == 5) begin
        hold_req <= 1'b1;
        for (int i = 0; i < 100; i++) pending_particles.push_back(near_particle());
      end
      for (int i = 0; i < N_RANDOM / 17; i++) begin
        if ($urandom_range(0, 4) == 0) p = noise_particle();
        else p = near_particle();
        pending_particles.push_back(p);
      end
      drain();
    end

    if (errors == 0) begin
      $display("axis_force_particle_update_top_test: PASS");
    end else begin
      $display("axis_force_particle_update_top_test: FAIL");
    end
    $finish;
  end

endmodule
